// ----- design/sdq_pkg.sv -----
// ---------------------------------------------------------------------------
// sdq_pkg - shared definitions for the searchable deque
// Sizes, operation and status codes, and the structs passed between the
// cell row, the match scanner and the top level.
// ---------------------------------------------------------------------------
`default_nettype none

package sdq_pkg;

    // store size and derived widths
    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int GRP_W    = 8;                              // match bits per scan step
    localparam int NGRP     = (CAPACITY + GRP_W - 1) / GRP_W; // scan steps per query
    localparam int GIDX_W   = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int PAD_W    = NGRP * GRP_W;

    // field widths
    localparam int OP_W     = 3;
    localparam int VAL_W    = 32;
    localparam int STAT_W   = 2;
    localparam int POS_W    = 8;
    localparam int MCNT_W   = 7;
    localparam int LEN_W    = 7;
    localparam int IN_W     = 40;
    localparam int OUT_W    = 32;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY      = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop_front;
        logic pop_back;
        logic compare;
    } sdq_cell_ctrl_t;

    // query summary from the scanner
    typedef struct packed {
        logic             found;
        logic [CNT_W-1:0] first;
        logic [CNT_W-1:0] count;
    } sdq_scan_res_t;

endpackage

`default_nettype wire

// ----- design/sdq_cell.sv -----
// ---------------------------------------------------------------------------
// sdq_cell - one storage cell of the deque row
// Holds one entry and its occupancy bit, shifts towards either neighbour,
// loads at the back boundary and registers a compare against the key.
// ---------------------------------------------------------------------------
`default_nettype none

module sdq_cell (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire sdq_pkg::sdq_cell_ctrl_t ctrl,
    input  wire signed [31:0]          value,
    input  wire signed [31:0]          prev_data,   // cell nearer the front
    input  wire                        prev_valid,
    input  wire signed [31:0]          next_data,   // cell nearer the back
    input  wire                        next_valid,
    output logic signed [31:0]         data,
    output logic                       valid,
    output logic                       match
);

    logic signed [31:0] data_reg;
    logic signed [31:0] data_next;
    logic               valid_reg;
    logic               valid_next;
    logic               match_reg;

    // next entry and occupancy
    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (ctrl.push_front)
        begin
            data_next  = prev_data;
            valid_next = prev_valid;
        end
        else if (ctrl.pop_front)
        begin
            data_next  = next_data;
            valid_next = next_valid;
        end
        else if (ctrl.push_back)
        begin
            // first free cell behind the occupied run takes the request
            if (!valid_reg && prev_valid)
            begin
                data_next  = value;
                valid_next = 1'b1;
            end
        end
        else if (ctrl.pop_back)
        begin
            // last occupied cell drops out
            if (valid_reg && !next_valid)
            begin
                valid_next = 1'b0;
            end
        end
    end

    // entry payload, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    // occupancy and match flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (ctrl.compare)
            begin
                match_reg <= valid_reg && (data_reg == value);
            end
        end
    end

    assign data  = data_reg;
    assign valid = valid_reg;
    assign match = match_reg;

endmodule

`default_nettype wire

// ----- design/sdq_scan.sv -----
// ---------------------------------------------------------------------------
// sdq_scan - match vector scanner
// Walks the registered match bits one group per cycle from the front,
// counting matches and noting the first matching position.
// ---------------------------------------------------------------------------
`default_nettype none

module sdq_scan (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              start,
    input  wire [sdq_pkg::CAPACITY-1:0]      match_vec,
    output logic                             done,
    output sdq_pkg::sdq_scan_res_t           res
);

    logic                             busy_reg;
    logic                             done_reg;
    logic [sdq_pkg::GIDX_W-1:0]       grp_reg;
    logic                             found_reg;
    logic [sdq_pkg::CNT_W-1:0]        first_reg;
    logic [sdq_pkg::CNT_W-1:0]        cnt_reg;

    logic [sdq_pkg::PAD_W-1:0]        match_pad;
    logic [sdq_pkg::GRP_W-1:0]        bits;
    logic [3:0]                       pop;
    logic [2:0]                       first_idx;
    logic                             any;
    logic                             last_grp;

    assign match_pad = sdq_pkg::PAD_W'(match_vec);
    assign bits      = match_pad[grp_reg*sdq_pkg::GRP_W +: sdq_pkg::GRP_W];
    assign last_grp  = (grp_reg == sdq_pkg::GIDX_W'(sdq_pkg::NGRP - 1));

    // group popcount and first set bit
    always_comb
    begin
        pop       = 4'd0;
        first_idx = 3'd0;
        any       = |bits;
        for (int k = 0; k < sdq_pkg::GRP_W; k++)
        begin
            pop = pop + 4'(bits[k]);
        end
        for (int k = sdq_pkg::GRP_W - 1; k >= 0; k--)
        begin
            if (bits[k])
            begin
                first_idx = 3'(k);
            end
        end
    end

    // scan sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            grp_reg   <= '0;
            found_reg <= 1'b0;
            first_reg <= '0;
            cnt_reg   <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
            grp_reg   <= '0;
            found_reg <= 1'b0;
            first_reg <= '0;
            cnt_reg   <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + sdq_pkg::CNT_W'(pop);
            if (!found_reg && any)
            begin
                found_reg <= 1'b1;
                first_reg <= sdq_pkg::CNT_W'({grp_reg, first_idx}) + sdq_pkg::CNT_W'(1);
            end
            if (last_grp)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                grp_reg <= grp_reg + sdq_pkg::GIDX_W'(1);
            end
        end
    end

    assign done      = done_reg;
    assign res.found = found_reg;
    assign res.first = first_reg;
    assign res.count = cnt_reg;

endmodule

`default_nettype wire

// ----- design/searchable_double_ended_queue_core.sv -----
// ---------------------------------------------------------------------------
// searchable_double_ended_queue_core - bounded deque with content search
// Row of shifting cells holds the sequence front first; queries compare all
// cells at once and a scanner reduces the match bits.
// ---------------------------------------------------------------------------
// Inserts and removals: result registered as the request is taken; next request
// may follow in the next cycle once the receiver takes that result.
// Queries: cells register the compare, the match scanner reduces one group per
// cycle, then the result is registered once the output is free; no request taken meanwhile.
// Reset (rst_n, async, active low) empties the deque; no clearing pass.
`default_nettype none

module searchable_double_ended_queue_core (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [39:0]  s_tdata,    // op[2:0], value[34:3], zero [39:35]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata     // status[1:0], found[2], first_position[10:3],
                                    // match_count[17:11], length[24:18], zero [31:25]
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                           state_reg;
    logic                           state_next;
    logic [sdq_pkg::CNT_W-1:0]      count_reg;
    logic [sdq_pkg::CNT_W-1:0]      count_next;
    logic                           out_valid_reg;
    logic [sdq_pkg::OUT_W-1:0]      out_data_reg;
    logic                           out_valid_next;
    logic [sdq_pkg::OUT_W-1:0]      out_data_next;

    logic [sdq_pkg::OP_W-1:0]       op;
    logic signed [31:0]             value;
    logic                           accept;
    logic                           out_free;
    logic                           full;
    logic                           empty;
    logic [sdq_pkg::STAT_W-1:0]     status;
    sdq_pkg::sdq_cell_ctrl_t        ctrl;
    logic                           scan_done;
    sdq_pkg::sdq_scan_res_t         scan_res;
    logic [sdq_pkg::POS_W-1:0]      first_pos;

    logic signed [31:0]             data_arr [sdq_pkg::CAPACITY];
    logic [sdq_pkg::CAPACITY-1:0]   valid_vec;
    logic [sdq_pkg::CAPACITY-1:0]   match_vec;

    // request fields
    assign op    = s_tdata[2:0];
    assign value = s_tdata[34:3];

    // handshake
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == sdq_pkg::CNT_W'(sdq_pkg::CAPACITY));
    assign empty    = (count_reg == '0);

    // decode request into cell commands and new length
    always_comb
    begin
        ctrl       = '0;
        status     = sdq_pkg::STAT_OK;
        count_next = count_reg;
        if (accept)
        begin
            unique case (op)
                sdq_pkg::OP_PUSH_FRONT, sdq_pkg::OP_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status = sdq_pkg::STAT_FULL;
                    end
                    else
                    begin
                        ctrl.push_front = (op == sdq_pkg::OP_PUSH_FRONT);
                        ctrl.push_back  = (op == sdq_pkg::OP_PUSH_BACK);
                        count_next      = count_reg + sdq_pkg::CNT_W'(1);
                    end
                end
                sdq_pkg::OP_POP_FRONT, sdq_pkg::OP_POP_BACK:
                begin
                    if (empty)
                    begin
                        status = sdq_pkg::STAT_EMPTY;
                    end
                    else
                    begin
                        ctrl.pop_front = (op == sdq_pkg::OP_POP_FRONT);
                        ctrl.pop_back  = (op == sdq_pkg::OP_POP_BACK);
                        count_next     = count_reg - sdq_pkg::CNT_W'(1);
                    end
                end
                sdq_pkg::OP_QUERY:
                begin
                    ctrl.compare = 1'b1;
                end
                default:
                begin
                    // undefined codes leave everything as it is
                end
            endcase
        end
    end

    // cell row, front at index 0
    for (genvar i = 0; i < sdq_pkg::CAPACITY; i++)
    begin : g_cell
        logic signed [31:0] prev_data;
        logic               prev_valid;
        logic signed [31:0] next_data;
        logic               next_valid;

        if (i == 0)
        begin : g_front
            assign prev_data  = value;
            assign prev_valid = 1'b1;
        end
        else
        begin : g_mid_front
            assign prev_data  = data_arr[i-1];
            assign prev_valid = valid_vec[i-1];
        end

        if (i == sdq_pkg::CAPACITY - 1)
        begin : g_back
            assign next_data  = '0;
            assign next_valid = 1'b0;
        end
        else
        begin : g_mid_back
            assign next_data  = data_arr[i+1];
            assign next_valid = valid_vec[i+1];
        end

        sdq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .value      (value),
            .prev_data  (prev_data),
            .prev_valid (prev_valid),
            .next_data  (next_data),
            .next_valid (next_valid),
            .data       (data_arr[i]),
            .valid      (valid_vec[i]),
            .match      (match_vec[i])
        );
    end

    // match reduction
    sdq_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (ctrl.compare),
        .match_vec (match_vec),
        .done      (scan_done),
        .res       (scan_res)
    );

    assign first_pos = scan_res.found ? sdq_pkg::POS_W'(scan_res.first) : '1;

    // sequencing and result register
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (op == sdq_pkg::OP_QUERY)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = {7'd0, sdq_pkg::LEN_W'(count_next), 7'd0, 8'd0,
                                          1'b0, status};
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_done && out_free)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    out_data_next  = {7'd0, sdq_pkg::LEN_W'(count_reg),
                                      sdq_pkg::MCNT_W'(scan_res.count), first_pos,
                                      scan_res.found, sdq_pkg::STAT_OK};
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // occupied cells always form the length
    a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == 32'(count_reg))
        else $error("cell occupancy disagrees with length");

    // length stays within the store
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= sdq_pkg::CNT_W'(sdq_pkg::CAPACITY))
        else $error("length beyond capacity");

    // no request taken while a query is being reduced
    a_scan_block: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> !s_tready)
        else $error("request accepted during scan");

    // insert into a full store leaves the length alone
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        accept && full && (op == sdq_pkg::OP_PUSH_FRONT || op == sdq_pkg::OP_PUSH_BACK)
        |=> $stable(count_reg))
        else $error("length changed on full insert");
`endif

endmodule

`default_nettype wire

// ----- test/searchable_double_ended_queue_core_tb.sv -----
// ---------------------------------------------------------------------------
// searchable_double_ended_queue_core_tb - self-checking bench for the deque
// Drives insert, remove and query requests over the slave stream and checks
// every result on the master stream against its table row or a behavioural deque model.
// A short table of directed requests comes first. Random walks follow, which
// fill the store, drain it and search it. The bench runs through phases with
// idle and stall patterns on both streams, and one long receiver hold-off.
// ---------------------------------------------------------------------------
`default_nettype none

module searchable_double_ended_queue_core_tb;

    import sdq_pkg::*;

    // request codes the block ignores
    localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    localparam logic [POS_W-1:0] POS_NONE  = '1;     // -1: value absent
    localparam int               HOLD_CYC  = 400;    // long receiver hold-off
    localparam int               DRAIN_CYC = 2 + CAPACITY / 8 + 6;
    localparam int               PHASE_N   = 255;    // minimum defined requests per phase
    localparam int               NUM_ROWS  = 25;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              found;
        logic [POS_W-1:0]  first_position;
        logic [MCNT_W-1:0] match_count;
        logic [LEN_W-1:0]  length;
    } deque_res_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [VAL_W-1:0] value;
        logic             typed;     // 1: result below is checked as written
        deque_res_t       res;
    } req_row_t;

    // directed requests: empty store, spare codes, extremes, search order
    localparam req_row_t DIRECTED [NUM_ROWS] = '{
        '{OP_QUERY,      32'h0000_0000, 1'b1, '{STAT_OK,    1'b0, POS_NONE, 7'd0, 7'd0}},
        '{OP_POP_FRONT,  32'h0000_0000, 1'b1, '{STAT_EMPTY, 1'b0, 8'd0,     7'd0, 7'd0}},
        '{OP_POP_BACK,   32'hFFFF_FFFF, 1'b1, '{STAT_EMPTY, 1'b0, 8'd0,     7'd0, 7'd0}},
        '{OP_SPARE_5,    32'h5555_5555, 1'b1, '{STAT_OK,    1'b0, 8'd0,     7'd0, 7'd0}},
        '{OP_SPARE_6,    32'hAAAA_AAAA, 1'b1, '{STAT_OK,    1'b0, 8'd0,     7'd0, 7'd0}},
        '{OP_SPARE_7,    32'hFFFF_FFFF, 1'b1, '{STAT_OK,    1'b0, 8'd0,     7'd0, 7'd0}},
        '{OP_PUSH_FRONT, 32'h8000_0000, 1'b1, '{STAT_OK,    1'b0, 8'd0,     7'd0, 7'd1}},
        '{OP_PUSH_BACK,  32'h7FFF_FFFF, 1'b1, '{STAT_OK,    1'b0, 8'd0,     7'd0, 7'd2}},
        '{OP_PUSH_FRONT, 32'h0000_0000, 1'b1, '{STAT_OK,    1'b0, 8'd0,     7'd0, 7'd3}},
        '{OP_PUSH_BACK,  32'hFFFF_FFFF, 1'b1, '{STAT_OK,    1'b0, 8'd0,     7'd0, 7'd4}},
        '{OP_QUERY,      32'h8000_0000, 1'b1, '{STAT_OK,    1'b1, 8'd2,     7'd1, 7'd4}},
        '{OP_QUERY,      32'h7FFF_FFFF, 1'b1, '{STAT_OK,    1'b1, 8'd3,     7'd1, 7'd4}},
        '{OP_QUERY,      32'hFFFF_FFFF, 1'b1, '{STAT_OK,    1'b1, 8'd4,     7'd1, 7'd4}},
        '{OP_QUERY,      32'h0000_0000, 1'b1, '{STAT_OK,    1'b1, 8'd1,     7'd1, 7'd4}},
        '{OP_PUSH_BACK,  32'h0000_0000, 1'b1, '{STAT_OK,    1'b0, 8'd0,     7'd0, 7'd5}},
        '{OP_QUERY,      32'h0000_0000, 1'b1, '{STAT_OK,    1'b1, 8'd1,     7'd2, 7'd5}},
        '{OP_POP_FRONT,  32'hAAAA_5555, 1'b1, '{STAT_OK,    1'b0, 8'd0,     7'd0, 7'd4}},
        '{OP_QUERY,      32'h0000_0000, 1'b1, '{STAT_OK,    1'b1, 8'd4,     7'd1, 7'd4}},
        '{OP_POP_BACK,   32'h0000_0000, 1'b1, '{STAT_OK,    1'b0, 8'd0,     7'd0, 7'd3}},
        '{OP_QUERY,      32'h0000_0000, 1'b1, '{STAT_OK,    1'b0, POS_NONE, 7'd0, 7'd3}},
        '{OP_SPARE_5,    32'h7FFF_FFFF, 1'b1, '{STAT_OK,    1'b0, 8'd0,     7'd0, 7'd3}},
        '{OP_QUERY,      32'h1234_5678, 1'b0, '0},
        '{OP_POP_BACK,   32'h0000_0000, 1'b1, '{STAT_OK,    1'b0, 8'd0,     7'd0, 7'd2}},
        '{OP_POP_FRONT,  32'h0000_0000, 1'b1, '{STAT_OK,    1'b0, 8'd0,     7'd0, 7'd1}},
        '{OP_POP_BACK,   32'h0000_0000, 1'b1, '{STAT_OK,    1'b0, 8'd0,     7'd0, 7'd0}}
    };

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [39:0] s_tdata  = '0;    // op[2:0], value[34:3], zero [39:35]
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [31:0] m_tdata;          // status[1:0], found[2], first_position[10:3],
                                   // match_count[17:11], length[24:18], zero [31:25]

    // model state, front entry at index 0
    logic [VAL_W-1:0] model_seq[$];
    deque_res_t       pending_results[$];
    logic [VAL_W-1:0] value_pool [16];

    int bad_results  = 0;
    int items_sent   = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_asked   = 0;
    int hold_served  = 0;
    int hold_left    = 0;

    always #5 clk = ~clk;

    searchable_double_ended_queue_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // apply one request to the model and return the result it should give
    function automatic deque_res_t deque_apply(input logic [OP_W-1:0] op,
                                               input logic [VAL_W-1:0] value);
        deque_res_t r;
        r = '0;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (model_seq.size() >= CAPACITY)
                    r.status = STAT_FULL;
                else if (op == OP_PUSH_FRONT)
                    model_seq.push_front(value);
                else
                    model_seq.push_back(value);
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                if (model_seq.size() == 0)
                    r.status = STAT_EMPTY;
                else if (op == OP_POP_FRONT)
                    void'(model_seq.pop_front());
                else
                    void'(model_seq.pop_back());
            end
            OP_QUERY:
            begin
                r.first_position = POS_NONE;
                foreach (model_seq[i])
                begin
                    if (model_seq[i] == value)
                    begin
                        if (!r.found)
                            r.first_position = POS_W'(i + 1);
                        r.found = 1'b1;
                        r.match_count = r.match_count + 1'b1;
                    end
                end
            end
            default: ;  // spare codes leave everything alone
        endcase
        r.length = LEN_W'(model_seq.size());
        return r;
    endfunction

    // offer one request, wait for it to be taken, then log its expected result
    task automatic send_req(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] value,
                            input logic typed, input deque_res_t typed_res);
        int         gap;
        deque_res_t r;
        gap = 0;
        while (gap < 60 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, value, op};
        do
            @(posedge clk);
        while (!s_tready);
        r = deque_apply(op, value);
        pending_results.push_back(typed ? typed_res : r);
        if (op <= OP_QUERY)
            items_sent++;
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        if ($urandom_range(99) < 85)
            return value_pool[$urandom_range(15)];
        return $urandom;
    endfunction

    // one run of requests: walk the length to a target, then keep requesting around it
    task automatic run_walk(input int target, input int pool_n, input bit noise);
        int               steps;
        int               r;
        int               len;
        bit               reached;
        logic [OP_W-1:0]  op;
        logic [VAL_W-1:0] v;
        for (int i = 0; i < 16; i++)
        begin
            case ($urandom_range(7))
                0:       value_pool[i] = 32'h8000_0000;
                1:       value_pool[i] = 32'h7FFF_FFFF;
                2:       value_pool[i] = 32'hFFFF_FFFF;
                3:       value_pool[i] = 32'h0000_0000;
                default: value_pool[i] = $urandom;
            endcase
            if (i >= pool_n)
                value_pool[i] = value_pool[i % pool_n];
        end
        steps   = noise ? $urandom_range(10, 40) : $urandom_range(1, 5);
        reached = noise;
        while (steps > 0)
        begin
            len = model_seq.size();
            r   = $urandom_range(99);
            v   = pick_value();
            if (noise)
            begin
                op = OP_W'($urandom_range(7));
                v  = $urandom;
            end
            else if (r < 2)
                op = OP_W'($urandom_range(OP_SPARE_5, OP_SPARE_7));
            else if (r < 27)
                op = OP_QUERY;
            else if ((len < target || target == CAPACITY) && r >= 37)
                op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
            else if (len > target || target == 0 || r < 37)
                op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
            else
                op = OP_QUERY;
            send_req(op, v, 1'b0, '0);
            if (model_seq.size() == target)
                reached = 1'b1;
            if (reached)
                steps--;
        end
    endtask

    // result checker and receiver ready pattern
    always @(posedge clk)
    begin
        deque_res_t got;
        deque_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status         = m_tdata[1:0];
            got.found          = m_tdata[2];
            got.first_position = m_tdata[10:3];
            got.match_count    = m_tdata[17:11];
            got.length         = m_tdata[24:18];
            if (pending_results.size() == 0)
            begin
                if (bad_results < 10)
                    $display("unexpected result %p", got);
                bad_results++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status != want.status || got.found != want.found ||
                    got.first_position != want.first_position ||
                    got.match_count != want.match_count || got.length != want.length)
                begin
                    if (bad_results < 10)
                        $display("result wrong: expected %p, got %p", want, got);
                    bad_results++;
                end
            end
        end
        // long hold-off on request, otherwise random stalls
        if (hold_served != hold_asked)
        begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYC;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // stimulus
    initial
    begin
        int idle_tab  [4];
        int stall_tab [4];
        int phase_end;
        int sel;
        idle_tab  = '{0, 82, 0, 18};
        stall_tab = '{0, 0, 82, 18};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_ROWS; i++)
            send_req(DIRECTED[i].op, DIRECTED[i].value, DIRECTED[i].typed, DIRECTED[i].res);

        // random phases; the first opens with the receiver held off while filling
        hold_asked++;
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = idle_tab[ph];
            recv_stall_pct = stall_tab[ph];
            phase_end      = items_sent + PHASE_N;
            run_walk(CAPACITY, 3, 1'b0);
            while (items_sent < phase_end)
            begin
                sel = $urandom_range(9);
                if (sel < 2)
                    run_walk(0, 16, 1'b1);
                else if (sel < 4)
                    run_walk(0, 4, 1'b0);
                else if (sel < 6)
                    run_walk(CAPACITY, (sel == 4) ? 1 : 16, 1'b0);
                else
                    run_walk($urandom_range(CAPACITY), 3, 1'b0);
            end
        end
        s_tvalid <= 1'b0;
        recv_stall_pct = 0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        if (bad_results == 0)
            $display("searchable_double_ended_queue_core: match");
        else
            $display("searchable_double_ended_queue_core: mismatch");
        $finish;
    end

    // watchdog
    initial
    begin
        #3_000_000;
        $display("searchable_double_ended_queue_core: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
